### sv/tpd_pkg.sv
// Shared types, codes and the bytewise CRC-32 update for the transport packet decoder.
package tpd_pkg;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// Report status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_ERR  = 2'd1;
	localparam logic [1:0] ST_INCONS   = 2'd2;
	localparam logic [1:0] ST_LEN_ERR  = 2'd3;

	// Packet type that may carry the truncated bit
	localparam logic [1:0] TYPE_DATA = 2'd1;

	localparam logic [14:0] MAX_PAYLOAD_RST = 15'd512;
	localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

	// One result transaction
	typedef struct packed {
		logic        out_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  pkt_type;
		logic        truncated;
		logic [4:0]  window;
		logic [14:0] payload_length;
		logic [7:0]  seq_num;
		logic [31:0] timestamp;
		logic [1:0]  status;
	} result_t;

	// Output buffer occupancy seen by the input side
	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} buf_status_t;

	// Reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

### sv/transport_packet_decoder.sv
// Top level of the transport packet decoder: input register, parser, result buffer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  input    | in_valid / in_ready   | in_byte, frame_end
//  result   | out_valid / out_ready | out_kind, payload_byte, header fields, status
//  config   | cfg_wr_en             | cfg_wr_data (max_payload)
//
// One byte is taken per cycle into the input register while in_ready is high;
// the combinational CRC and parse step forms its result for the result buffer.
// Reset clears the frame state and sets max_payload to 512; no clearing pass.
// A stalled result sits in the output register; one more result fits in the skid
// entry, and in_ready drops only while both hold results and the input register is full.
module transport_packet_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  payload_byte,
	output logic [1:0]  pkt_type,
	output logic        truncated,
	output logic [4:0]  window,
	output logic [14:0] payload_length,
	output logic [7:0]  seq_num,
	output logic [31:0] timestamp,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [14:0] cfg_wr_data
);

	logic                 s1_valid_q;
	logic [7:0]           in_byte_s1;
	logic                 frame_end_s1;
	logic [14:0]          max_payload_q;
	logic                 consume;
	logic                 res_valid;
	tpd_pkg::result_t     res;
	tpd_pkg::result_t     out_res;
	tpd_pkg::buf_status_t buf_st;
	logic                 in_accept;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= tpd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	// Input register advances when the buffer can take one more result
	assign consume   = s1_valid_q && !buf_st.skid_valid;
	assign in_ready  = !s1_valid_q || consume;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (consume) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_byte_s1   <= in_byte;
			frame_end_s1 <= frame_end;
		end
	end

	tpd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (consume),
		.in_byte     (in_byte_s1),
		.frame_end   (frame_end_s1),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	tpd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res),
		.status    (buf_st)
	);

	assign out_kind       = out_res.out_kind;
	assign payload_byte   = out_res.payload_byte;
	assign pkt_type       = out_res.pkt_type;
	assign truncated      = out_res.truncated;
	assign window         = out_res.window;
	assign payload_length = out_res.payload_length;
	assign seq_num        = out_res.seq_num;
	assign timestamp      = out_res.timestamp;
	assign status         = out_res.status;

	// Checks
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		buf_st.skid_valid |-> (out_valid && buf_st.main_valid))
		else $error("skid entry holds a result while the output register is empty");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && buf_st.skid_valid))
		else $error("input stalled while the result buffer has room");

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> consume)
		else $error("parser produced a result without a byte");

	a_stalled_push_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && res_valid) |=> buf_st.skid_valid)
		else $error("result pushed under stall was not held in the skid entry");

endmodule

### sv/tpd_parser.sv
// Header/payload parser: frame state, CRC checks and result formation for one byte.
module tpd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           in_byte,
	input  logic                 frame_end,
	input  logic [14:0]          max_payload,
	output logic                 res_valid,
	output tpd_pkg::result_t     res
);

	localparam logic [3:0] PH_HDR  = 4'd0;
	localparam logic [3:0] PH_LEN0 = 4'd1;
	localparam logic [3:0] PH_LEN1 = 4'd2;
	localparam logic [3:0] PH_SEQ  = 4'd3;
	localparam logic [3:0] PH_TS   = 4'd4;
	localparam logic [3:0] PH_HCRC = 4'd5;
	localparam logic [3:0] PH_PAY  = 4'd6;
	localparam logic [3:0] PH_PCRC = 4'd7;
	localparam logic [3:0] PH_DONE = 4'd8;

	logic [3:0]  phase_q, nxt_phase;
	logic [14:0] cnt_q, nxt_cnt;
	logic [31:0] crc_q, nxt_crc;
	logic [1:0]  type_q, nxt_type;
	logic        trunc_q, nxt_trunc;
	logic [4:0]  win_q, nxt_win;
	logic [14:0] len_q, nxt_len;
	logic [7:0]  seq_q, nxt_seq;
	logic [31:0] ts_q, nxt_ts;
	logic [31:0] rcrc_q, nxt_rcrc;
	logic        fail_q, nxt_fail;

	logic [15:0] cnt_inc;
	logic [31:0] crc_upd;
	logic [31:0] rcrc_shift;
	logic        pay_out;
	logic [1:0]  st;

	assign cnt_inc    = {1'b0, cnt_q} + 16'd1;
	assign crc_upd    = tpd_pkg::crc32_byte(crc_q, in_byte);
	assign rcrc_shift = {rcrc_q[23:0], in_byte};

	// Next-state logic for one byte
	always_comb begin
		nxt_phase = phase_q;
		nxt_cnt   = cnt_q;
		nxt_crc   = crc_q;
		nxt_type  = type_q;
		nxt_trunc = trunc_q;
		nxt_win   = win_q;
		nxt_len   = len_q;
		nxt_seq   = seq_q;
		nxt_ts    = ts_q;
		nxt_rcrc  = rcrc_q;
		nxt_fail  = fail_q;
		pay_out   = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				nxt_type  = in_byte[7:6];
				nxt_trunc = (in_byte[7:6] == tpd_pkg::TYPE_DATA) ? in_byte[5] : 1'b0;
				nxt_win   = in_byte[4:0];
				nxt_crc   = crc_upd;
				nxt_phase = PH_LEN0;
			end
			PH_LEN0: begin
				nxt_crc = crc_upd;
				if (in_byte[7]) begin
					nxt_len   = {in_byte[6:0], 8'h00};
					nxt_phase = PH_LEN1;
				end else begin
					nxt_len   = {8'h00, in_byte[6:0]};
					nxt_phase = PH_SEQ;
				end
			end
			PH_LEN1: begin
				nxt_crc   = crc_upd;
				nxt_len   = len_q | {7'h00, in_byte};
				nxt_phase = PH_SEQ;
			end
			PH_SEQ: begin
				nxt_crc   = crc_upd;
				nxt_seq   = in_byte;
				nxt_cnt   = '0;
				nxt_phase = PH_TS;
			end
			PH_TS: begin
				nxt_crc = crc_upd;
				// first timestamp byte lands in the low lane
				nxt_ts  = ts_q | ({24'h000000, in_byte} << {cnt_q[1:0], 3'b000});
				if (cnt_inc >= 16'd4) begin
					nxt_cnt   = '0;
					nxt_rcrc  = '0;
					nxt_phase = PH_HCRC;
				end else begin
					nxt_cnt = cnt_inc[14:0];
				end
			end
			PH_HCRC: begin
				nxt_rcrc = rcrc_shift;
				if (cnt_inc >= 16'd4) begin
					if (!trunc_q && (~crc_q != rcrc_shift)) begin
						nxt_fail = 1'b1;
					end
					nxt_crc   = tpd_pkg::CRC_INIT;
					nxt_cnt   = '0;
					nxt_rcrc  = '0;
					nxt_phase = (len_q != 15'd0) ? PH_PAY : PH_DONE;
				end else begin
					nxt_cnt = cnt_inc[14:0];
				end
			end
			PH_PAY: begin
				nxt_crc = crc_upd;
				pay_out = 1'b1;
				if (cnt_inc >= {1'b0, len_q}) begin
					nxt_cnt   = '0;
					nxt_rcrc  = '0;
					nxt_phase = PH_PCRC;
				end else begin
					nxt_cnt = cnt_inc[14:0];
				end
			end
			PH_PCRC: begin
				nxt_rcrc = rcrc_shift;
				if (cnt_inc >= 16'd4) begin
					if (~crc_q != rcrc_shift) begin
						nxt_fail = 1'b1;
					end
					nxt_cnt   = '0;
					nxt_phase = PH_DONE;
				end else begin
					nxt_cnt = cnt_inc[14:0];
				end
			end
			PH_DONE: begin
				// trailing bytes before frame end are dropped
			end
			default: begin
			end
		endcase
	end

	// Report status priority: early end, then CRC, then length limit
	always_comb begin
		if (nxt_phase != PH_DONE) begin
			st = tpd_pkg::ST_INCONS;
		end else if (nxt_fail) begin
			st = tpd_pkg::ST_CRC_ERR;
		end else if (nxt_len > max_payload) begin
			st = tpd_pkg::ST_LEN_ERR;
		end else begin
			st = tpd_pkg::ST_OK;
		end
	end

	// Result: report wins over a payload byte on frame end
	always_comb begin
		res = '0;
		if (frame_end) begin
			res.out_kind       = tpd_pkg::KIND_REPORT;
			res.pkt_type       = nxt_type;
			res.truncated      = nxt_trunc;
			res.window         = nxt_win;
			res.payload_length = nxt_len;
			res.seq_num        = nxt_seq;
			res.timestamp      = nxt_ts;
			res.status         = st;
		end else begin
			res.out_kind     = tpd_pkg::KIND_PAYLOAD;
			res.payload_byte = in_byte;
		end
	end

	assign res_valid = en && (pay_out || frame_end);

	// Frame state; cleared after every report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			cnt_q   <= '0;
			crc_q   <= tpd_pkg::CRC_INIT;
			type_q  <= '0;
			trunc_q <= 1'b0;
			win_q   <= '0;
			len_q   <= '0;
			seq_q   <= '0;
			ts_q    <= '0;
			rcrc_q  <= '0;
			fail_q  <= 1'b0;
		end else if (en) begin
			if (frame_end) begin
				phase_q <= PH_HDR;
				cnt_q   <= '0;
				crc_q   <= tpd_pkg::CRC_INIT;
				type_q  <= '0;
				trunc_q <= 1'b0;
				win_q   <= '0;
				len_q   <= '0;
				seq_q   <= '0;
				ts_q    <= '0;
				rcrc_q  <= '0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= nxt_phase;
				cnt_q   <= nxt_cnt;
				crc_q   <= nxt_crc;
				type_q  <= nxt_type;
				trunc_q <= nxt_trunc;
				win_q   <= nxt_win;
				len_q   <= nxt_len;
				seq_q   <= nxt_seq;
				ts_q    <= nxt_ts;
				rcrc_q  <= nxt_rcrc;
				fail_q  <= nxt_fail;
			end
		end
	end

endmodule

### sv/tpd_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module tpd_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tpd_pkg::result_t      push_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tpd_pkg::result_t      out_data,
	output tpd_pkg::buf_status_t  status
);

	logic             main_valid_q;
	logic             skid_valid_q;
	tpd_pkg::result_t main_q;
	tpd_pkg::result_t skid_q;
	logic             pop;

	assign pop = main_valid_q && out_ready;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Data
	always_ff @(posedge clk) begin
		if (!main_valid_q) begin
			if (push) begin
				main_q <= push_data;
			end
		end else if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid         = main_valid_q;
	assign out_data          = main_q;
	assign status.main_valid = main_valid_q;
	assign status.skid_valid = skid_valid_q;

endmodule
